// ===== design/mkped_pkg.sv =====
// Shared types and constants for the multi-key press event detector.
// No dependencies; imported by every module of the block.
package mkped_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int PIN_W     = 4;
    localparam int KEY_IDX_W = 2;
    localparam int FLAG_W    = 7;
    localparam int PERIOD_W  = 10;
    localparam int TIMER_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    // Flag bit positions
    localparam int FLAG_HOLD_BIT   = 0;
    localparam int FLAG_DOWN_BIT   = 1;
    localparam int FLAG_UP_BIT     = 2;
    localparam int FLAG_SINGLE_BIT = 3;
    localparam int FLAG_DOUBLE_BIT = 4;
    localparam int FLAG_LONG_BIT   = 5;
    localparam int FLAG_REPEAT_BIT = 6;

    localparam logic [FLAG_W-1:0] FLAG_HOLD_MASK = 7'h01;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT        = 2'd3;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 10'd20;
    localparam logic [TIMER_W-1:0]  LONG_PRESS_RST    = 15'd2000;
    localparam logic [TIMER_W-1:0]  DOUBLE_WINDOW_RST = 15'd200;
    localparam logic [TIMER_W-1:0]  REPEAT_RST        = 15'd100;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PRESSED = 3'd1,
        ST_WAIT    = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_LONG    = 3'd4
    } press_state_t;

    typedef struct packed {
        logic                 cmd;
        logic [PIN_W-1:0]     pin_levels;
        logic [KEY_IDX_W-1:0] key_index;
        logic [FLAG_W-1:0]    flag_mask;
    } mkped_in_t;

    typedef struct packed {
        logic              check_hit;
        logic [FLAG_W-1:0] key_flags;
    } mkped_out_t;

    // Per-key control for one processed item
    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              down;
        logic              clear;
        logic [FLAG_W-1:0] clear_mask;
    } key_ctrl_t;

    typedef struct packed {
        logic [TIMER_W-1:0] long_press;
        logic [TIMER_W-1:0] double_window;
        logic [TIMER_W-1:0] repeat_period;
    } key_timing_t;

endpackage

// ===== design/mkped_divider.sv =====
// Sample divider: counts ticks and fires once every sample_period ticks.
// Depends on mkped_pkg.
module mkped_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           tick,
    input  logic [mkped_pkg::PERIOD_W-1:0] period,
    output logic                           fire
);
    import mkped_pkg::*;

    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic [PERIOD_W:0]   count_inc;

    assign count_inc = {1'b0, count_reg} + {{PERIOD_W{1'b0}}, 1'b1};

    always_comb begin
        fire       = 1'b0;
        count_next = count_reg;
        if (tick) begin
            if (count_inc >= {1'b0, period}) begin
                fire       = 1'b1;
                count_next = '0;
            end else begin
                count_next = count_inc[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/mkped_key.sv =====
// One key: countdown timer, sample history, press state machine, sticky flags.
// Depends on mkped_pkg.
module mkped_key (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mkped_pkg::key_ctrl_t         ctrl,
    input  mkped_pkg::key_timing_t       timing,
    output logic [mkped_pkg::FLAG_W-1:0] flags
);
    import mkped_pkg::*;

    press_state_t       state_reg, state_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [TIMER_W-1:0] timer_dec;
    logic               cur_reg, cur_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [FLAG_W-1:0]  f;
    logic               timer_zero;

    assign timer_dec  = (timer_reg != '0) ? timer_reg - {{(TIMER_W-1){1'b0}}, 1'b1} : timer_reg;
    assign timer_zero = (timer_dec == '0);
    assign flags      = flags_reg;

    always_comb begin
        state_next = state_reg;
        timer_next = timer_reg;
        cur_next   = cur_reg;
        flags_next = flags_reg;
        f          = flags_reg;
        if (ctrl.tick) begin
            timer_next = timer_dec;
            if (ctrl.sample) begin
                cur_next         = ctrl.down;
                f[FLAG_HOLD_BIT] = ctrl.down;
                if (ctrl.down && !cur_reg) begin
                    f[FLAG_DOWN_BIT] = 1'b1;
                end
                if (!ctrl.down && cur_reg) begin
                    f[FLAG_UP_BIT] = 1'b1;
                end
                // timer checks see the value after this tick's countdown
                unique case (state_reg)
                    ST_IDLE: begin
                        if (ctrl.down) begin
                            timer_next = timing.long_press;
                            state_next = ST_PRESSED;
                        end
                    end
                    ST_PRESSED: begin
                        if (!ctrl.down) begin
                            timer_next = timing.double_window;
                            state_next = ST_WAIT;
                        end else if (timer_zero) begin
                            f[FLAG_LONG_BIT] = 1'b1;
                            timer_next       = timing.repeat_period;
                            state_next       = ST_LONG;
                        end
                    end
                    ST_WAIT: begin
                        if (ctrl.down) begin
                            f[FLAG_DOUBLE_BIT] = 1'b1;
                            state_next         = ST_DOUBLE;
                        end else if (timer_zero) begin
                            f[FLAG_SINGLE_BIT] = 1'b1;
                            state_next         = ST_IDLE;
                        end
                    end
                    ST_DOUBLE: begin
                        if (!ctrl.down) begin
                            state_next = ST_IDLE;
                        end
                    end
                    ST_LONG: begin
                        if (!ctrl.down) begin
                            state_next = ST_IDLE;
                        end else if (timer_zero) begin
                            f[FLAG_REPEAT_BIT] = 1'b1;
                            timer_next         = timing.repeat_period;
                        end
                    end
                    default: begin
                    end
                endcase
                flags_next = f;
            end
        end else if (ctrl.clear) begin
            flags_next = flags_reg & ~ctrl.clear_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            timer_reg <= '0;
            cur_reg   <= 1'b0;
            flags_reg <= '0;
        end else begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            cur_reg   <= cur_next;
            flags_reg <= flags_next;
        end
    end

endmodule

// ===== design/multi_key_press_event_detector.sv =====
// Multi-key press event detector, top level.
// Depends on mkped_pkg, mkped_divider and mkped_key.
//
// Input channel s_*: one item per transfer. cmd tick carries active-low pin
// levels; every running key timer counts down and, every sample_period
// ticks, all keys are sampled and their press machines advance. cmd check
// reads one key's flags, reports whether any masked flag was set and clears
// the masked flags, except when the mask is the hold bit alone.
// Result channel m_*: exactly one result per item, in order; ticks give 0.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at once;
// write only while no item is in flight.
// An item transferred into the input register is processed once the
// result register is free or draining, and its result is registered
// there. Throughput is one item per cycle while m_ready stays high, set
// by the single processing stage between the input and result registers.
// Reset clears all flags, timers, press machines and the divider and loads
// the default timings. When m_ready is low the result register holds and
// the input register takes one more item before s_ready drops.
module multi_key_press_event_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mkped_pkg::mkped_in_t            s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mkped_pkg::mkped_out_t           m_data,
    input  logic                            cfg_wr_en,
    input  logic [mkped_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mkped_pkg::CFG_W-1:0]     cfg_wdata
);
    import mkped_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    key_timing_t         timing_reg;

    logic       in_valid_reg;
    mkped_in_t  in_reg;
    logic       out_valid_reg;
    mkped_out_t out_reg;
    mkped_out_t out_next;

    logic              advance;
    logic              is_tick;
    logic              is_check;
    logic              sample_fire;
    logic              idx_ok;
    logic [FLAG_W-1:0] sel_flags;
    logic              hit;
    logic [FLAG_W-1:0] key_flags_w [NUM_KEYS];

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign is_tick  = advance && (in_reg.cmd == CMD_TICK);
    assign is_check = advance && (in_reg.cmd == CMD_CHECK);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg               <= SAMPLE_PERIOD_RST;
            timing_reg.long_press    <= LONG_PRESS_RST;
            timing_reg.double_window <= DOUBLE_WINDOW_RST;
            timing_reg.repeat_period <= REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: period_reg               <= cfg_wdata[PERIOD_W-1:0];
                REG_LONG_PRESS:    timing_reg.long_press    <= cfg_wdata[TIMER_W-1:0];
                REG_DOUBLE_WINDOW: timing_reg.double_window <= cfg_wdata[TIMER_W-1:0];
                REG_REPEAT:        timing_reg.repeat_period <= cfg_wdata[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    mkped_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (is_tick),
        .period  (period_reg),
        .fire    (sample_fire)
    );

    assign idx_ok    = (int'(in_reg.key_index) < NUM_KEYS);
    assign sel_flags = idx_ok ? key_flags_w[in_reg.key_index] : '0;
    assign hit       = ((sel_flags & in_reg.flag_mask) != '0);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        key_ctrl_t ctrl;
        logic      pin;

        // keys without a pin read level 0, i.e. pressed
        if (k < PIN_W) begin : g_pin
            assign pin = in_reg.pin_levels[k];
        end else begin : g_nopin
            assign pin = 1'b0;
        end

        assign ctrl.tick       = is_tick;
        assign ctrl.sample     = sample_fire;
        assign ctrl.down       = !pin;
        assign ctrl.clear      = is_check && (int'(in_reg.key_index) == k) && hit
                                 && (in_reg.flag_mask != FLAG_HOLD_MASK);
        assign ctrl.clear_mask = in_reg.flag_mask;

        mkped_key u_key (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .timing  (timing_reg),
            .flags   (key_flags_w[k])
        );
    end

    always_comb begin
        out_next.check_hit = 1'b0;
        out_next.key_flags = '0;
        if (in_reg.cmd == CMD_CHECK) begin
            out_next.check_hit = hit;
            out_next.key_flags = sel_flags;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Assertions

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but s_ready low");

    a_tick_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick |=> (out_reg.check_hit == 1'b0) && (out_reg.key_flags == '0))
        else $error("tick transfer produced a nonzero result");

    a_hold_check_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_check && (in_reg.flag_mask == FLAG_HOLD_MASK))
        |=> key_flags_w[$past(in_reg.key_index)] == $past(sel_flags))
        else $error("hold-only check changed key flags");

    a_hit_implies_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.check_hit) |-> (m_data.key_flags != '0))
        else $error("hit reported with no flags set");

endmodule

// ===== test/multi_key_press_event_detector_tb.sv =====
// Self-checking testbench for multi_key_press_event_detector: a directed table,
// then random phases of tick/check traffic under several timing settings.
// Depends on mkped_pkg and the detector RTL only.
module multi_key_press_event_detector_tb;
    import mkped_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int N_STEPS          = 31;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    mkped_in_t            s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    mkped_out_t           m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    multi_key_press_event_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Shadow copy of the detector state
    logic [PERIOD_W-1:0] period_q;
    logic [TIMER_W-1:0]  long_q;
    logic [TIMER_W-1:0]  dwin_q;
    logic [TIMER_W-1:0]  rpt_q;
    logic [10:0]         div_cnt;
    logic [FLAG_W-1:0]   key_flags_m [NUM_KEYS];
    press_state_t        press_m     [NUM_KEYS];
    logic [TIMER_W-1:0]  timer_m     [NUM_KEYS];
    logic                cur_m       [NUM_KEYS];
    logic                prev_m      [NUM_KEYS];

    mkped_out_t expected_events [$];
    int         mismatches   = 0;
    int         results_seen = 0;
    int         rx_stall     = 0;
    int         rx_gap_max   = 0;
    int         tx_gap_max   = 0;
    int         cycle_count  = 0;
    mkped_out_t want;

    // Pin pattern generator: per-key press/release durations
    logic [PIN_W-1:0] pin_state = '1;
    int               hold_left [PIN_W];

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     value;
        mkped_in_t            item;
        logic                 typed;
        mkped_out_t           result;
    } step_row_t;

    step_row_t directed_steps [N_STEPS];

    function automatic void sample_key_model(int k, logic down);
        logic [FLAG_W-1:0] f;
        f = key_flags_m[k];
        prev_m[k] = cur_m[k];
        cur_m[k] = down;
        f[FLAG_HOLD_BIT] = down;
        if (down && !prev_m[k]) f[FLAG_DOWN_BIT] = 1'b1;
        if (!down && prev_m[k]) f[FLAG_UP_BIT] = 1'b1;
        case (press_m[k])
            ST_IDLE: begin
                if (down) begin
                    timer_m[k] = long_q;
                    press_m[k] = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (!down) begin
                    timer_m[k] = dwin_q;
                    press_m[k] = ST_WAIT;
                end else if (timer_m[k] == '0) begin
                    f[FLAG_LONG_BIT] = 1'b1;
                    timer_m[k] = rpt_q;
                    press_m[k] = ST_LONG;
                end
            end
            ST_WAIT: begin
                if (down) begin
                    f[FLAG_DOUBLE_BIT] = 1'b1;
                    press_m[k] = ST_DOUBLE;
                end else if (timer_m[k] == '0) begin
                    f[FLAG_SINGLE_BIT] = 1'b1;
                    press_m[k] = ST_IDLE;
                end
            end
            ST_DOUBLE: begin
                if (!down) press_m[k] = ST_IDLE;
            end
            ST_LONG: begin
                if (!down) begin
                    press_m[k] = ST_IDLE;
                end else if (timer_m[k] == '0) begin
                    f[FLAG_REPEAT_BIT] = 1'b1;
                    timer_m[k] = rpt_q;
                end
            end
            default: ;
        endcase
        key_flags_m[k] = f;
    endfunction

    function automatic mkped_out_t predict_key_event(mkped_in_t it);
        mkped_out_t        res;
        logic [FLAG_W-1:0] f;
        res = '0;
        if (it.cmd == CMD_TICK) begin
            for (int k = 0; k < NUM_KEYS; k++)
                if (timer_m[k] != '0) timer_m[k] = timer_m[k] - 1'b1;
            div_cnt = div_cnt + 1'b1;
            if (div_cnt >= {1'b0, period_q}) begin
                div_cnt = '0;
                for (int k = 0; k < NUM_KEYS; k++)
                    sample_key_model(k, !it.pin_levels[k]);
            end
        end else begin
            f = key_flags_m[it.key_index];
            res.key_flags = f;
            if ((f & it.flag_mask) != '0) begin
                // hold alone is a pure read
                if (it.flag_mask != FLAG_HOLD_MASK)
                    key_flags_m[it.key_index] = f & ~it.flag_mask;
                res.check_hit = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int draw_hold();
        int per;
        int span;
        per = (period_q == '0) ? 1 : int'(period_q);
        if ($urandom_range(0, 1) == 0) span = 3 * per;
        else span = int'(long_q) + 3 * int'(rpt_q) + 3 * per;
        if (span > 400) span = 400;
        return int'($urandom_range(0, span));
    endfunction

    function automatic logic [PIN_W-1:0] next_pin_levels();
        for (int k = 0; k < PIN_W; k++) begin
            if (hold_left[k] == 0) begin
                pin_state[k] = ~pin_state[k];
                hold_left[k] = draw_hold();
            end else begin
                hold_left[k]--;
            end
        end
        if ($urandom_range(0, 15) == 0) return PIN_W'($urandom);
        return pin_state;
    endfunction

    function automatic step_row_t t_row(logic [PIN_W-1:0] pins);
        step_row_t r;
        r = '0;
        r.item.cmd = CMD_TICK;
        r.item.pin_levels = pins;
        return r;
    endfunction

    function automatic step_row_t c_row(logic [KEY_IDX_W-1:0] idx, logic [FLAG_W-1:0] mask);
        step_row_t r;
        r = '0;
        r.item.cmd = CMD_CHECK;
        r.item.pin_levels = '1;
        r.item.key_index = idx;
        r.item.flag_mask = mask;
        return r;
    endfunction

    function automatic step_row_t w_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic step_row_t known(step_row_t r, logic hit, logic [FLAG_W-1:0] flags);
        step_row_t o;
        o = r;
        o.typed = 1'b1;
        o.result.check_hit = hit;
        o.result.key_flags = flags;
        return o;
    endfunction

    task automatic send_item(input mkped_in_t it, input logic typed, input mkped_out_t typed_res);
        int         gap;
        mkped_out_t res;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = predict_key_event(it);
        expected_events.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SAMPLE_PERIOD: period_q = val[PERIOD_W-1:0];
            REG_LONG_PRESS:    long_q = val;
            REG_DOUBLE_WINDOW: dwin_q = val;
            REG_REPEAT:        rpt_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic run_phase(input int per, input int lp, input int dw, input int rp,
                             input int n, input int txg, input int rxg);
        mkped_in_t it;
        wait_idle();
        write_reg(REG_SAMPLE_PERIOD, CFG_W'(per));
        write_reg(REG_LONG_PRESS, CFG_W'(lp));
        write_reg(REG_DOUBLE_WINDOW, CFG_W'(dw));
        write_reg(REG_REPEAT, CFG_W'(rp));
        tx_gap_max = txg;
        rx_gap_max = rxg;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_idle();
            it.cmd = ($urandom_range(0, 9) < 3) ? CMD_CHECK : CMD_TICK;
            it.pin_levels = (it.cmd == CMD_TICK) ? next_pin_levels() : PIN_W'($urandom);
            it.key_index = KEY_IDX_W'($urandom);
            case ($urandom_range(0, 5))
                0:       it.flag_mask = '1;
                1:       it.flag_mask = FLAG_HOLD_MASK;
                2:       it.flag_mask = '0;
                3, 4:    it.flag_mask = FLAG_W'(1 << $urandom_range(0, FLAG_W - 1));
                default: it.flag_mask = FLAG_W'($urandom);
            endcase
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result transfer: hit %0d flags %0h",
                           m_data.check_hit, m_data.key_flags);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_data.check_hit !== want.check_hit) begin
                        $error("check_hit: expected %0d, got %0d",
                               want.check_hit, m_data.check_hit);
                        mismatches++;
                    end
                    if (m_data.key_flags !== want.key_flags) begin
                        $error("key_flags: expected %0h, got %0h",
                               want.key_flags, m_data.key_flags);
                        mismatches++;
                    end
                end
                results_seen++;
                rx_stall = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                         : int'($urandom_range(0, rx_gap_max));
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= (rx_stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        period_q = SAMPLE_PERIOD_RST;
        long_q   = LONG_PRESS_RST;
        dwin_q   = DOUBLE_WINDOW_RST;
        rpt_q    = REPEAT_RST;
        div_cnt  = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_flags_m[k] = '0;
            press_m[k]     = ST_IDLE;
            timer_m[k]     = '0;
            cur_m[k]       = 1'b0;
            prev_m[k]      = 1'b0;
        end
        for (int k = 0; k < PIN_W; k++) hold_left[k] = 0;

        directed_steps = '{
            known(c_row(2'd0, 7'h7F), 1'b0, 7'h00),   // fresh after reset
            known(c_row(2'd3, 7'h7F), 1'b0, 7'h00),
            known(t_row(4'hF), 1'b0, 7'h00),
            w_row(REG_SAMPLE_PERIOD, 15'd0),          // sample on every tick
            w_row(REG_LONG_PRESS, 15'd3),
            w_row(REG_DOUBLE_WINDOW, 15'd2),
            w_row(REG_REPEAT, 15'd1),
            t_row(4'h0),
            known(c_row(2'd0, FLAG_HOLD_MASK), 1'b1, 7'h03),  // hold-only read, no clear
            known(c_row(2'd0, 7'h00), 1'b0, 7'h03),
            t_row(4'h0),
            t_row(4'h0),
            t_row(4'h0),                              // long
            t_row(4'h0),                              // repeat
            c_row(2'd1, 7'h7F),
            t_row(4'hF),
            t_row(4'b1010),
            t_row(4'hF),
            t_row(4'b1010),                           // second press in window
            t_row(4'hF),
            t_row(4'hF),
            t_row(4'hF),
            c_row(2'd0, 7'h10),
            c_row(2'd2, 7'h7F),
            w_row(REG_SAMPLE_PERIOD, 15'd1023),
            t_row(4'h0),
            t_row(4'hF),
            w_row(REG_SAMPLE_PERIOD, 15'd1),          // now below the running count
            t_row(4'b0101),
            c_row(2'd0, 7'h7F),
            c_row(2'd3, 7'h40)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_gap_max = 2;
        rx_gap_max = 2;
        for (int i = 0; i < N_STEPS; i++) begin
            if (directed_steps[i].is_cfg) begin
                wait_idle();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].value);
            end else begin
                send_item(directed_steps[i].item, directed_steps[i].typed,
                          directed_steps[i].result);
            end
        end

        run_phase(1, 6, 4, 2, 400, 5, 5);
        run_phase(2, 10, 6, 3, 400, 0, 0);
        run_phase(3, 0, 0, 0, 350, 5, 5);
        run_phase($urandom_range(1, 4), $urandom_range(0, 20), $urandom_range(0, 12),
                  $urandom_range(0, 8), 400, 0, 5);
        run_phase(1023, 32767, 32767, 32767, 100, 2, 2);
        run_phase(1, 30, 8, 5, 350, 3, 1);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
